@@ rtl/lsdb_pkg.sv @@
`default_nettype none

package lsdb_pkg;

    // clamp limits of the configuration registers
    localparam logic [6:0]  MAX_BIT_SPAN = 7'd64;
    localparam logic [10:0] MAX_BUCKETS  = 11'd1024;

    // register indexes on the write port
    localparam logic [0:0] REG_BIT_SPAN     = 1'b0;
    localparam logic [0:0] REG_BUCKET_COUNT = 1'b1;
    localparam int unsigned CFG_DATA_W      = 11;

    // widths of the narrow datapath values
    localparam int unsigned PROD_W    = 18;  // bucket * span
    localparam int unsigned SCALED_W  = 17;  // log term scaled by bucket count
    localparam int unsigned DIV_STEPS = 4;   // quotient bits per divider stage

    typedef enum logic
    {
        OP_INDEX    = 1'b0,
        OP_BOUNDARY = 1'b1
    } op_t;

    typedef struct packed
    {
        logic        operation;
        logic [63:0] distance;
        logic [10:0] bucket;
    } in_word_t;

    typedef struct packed
    {
        logic [9:0]  bucket_index;
        logic [63:0] boundary;
    } out_word_t;

    // per-word control carried alongside the datapath
    typedef struct packed
    {
        op_t         op;
        logic        zero_dist;  // distance was zero
        logic        sat;        // boundary saturates to all ones
        logic        oob;        // bucket out of range
        logic [6:0]  expo;       // msb position, or boundary exponent
        logic [6:0]  span;
        logic [10:0] cnt;
    } info_t;

    typedef struct packed
    {
        info_t       info;
        logic [63:0] word;
    } carry_t;

    // integer square root of a 128-bit value, elaboration only
    function automatic logic [63:0] isqrt128(input logic [127:0] x);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [127:0] sq;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            c  = r | (64'd1 << b);
            sq = 128'(c) * 128'(c);
            if (sq <= x)
                r = c;
        end
        return r;
    endfunction

    // 2^(2^-k) in Q1.63, truncated at each square root
    function automatic logic [63:0] exp_root(input int k);
        logic [63:0] c;
        c = isqrt128({1'b1, 127'd0});
        for (int j = 2; j <= k; j++)
        begin
            c = isqrt128({1'b0, c, 63'd0});
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/lsdb_if.sv @@
`default_nettype none

interface lsdb_if #(parameter type word_t = logic) ();
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/lsdb_div.sv @@
`default_nettype none

module lsdb_div #(
    parameter int unsigned NUM_W = 18,
    parameter int unsigned DEN_W = 11
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    en,
    input  wire                    in_valid,
    input  wire  [NUM_W-1:0]       in_num,
    input  wire  [DEN_W-1:0]       in_den,
    input  lsdb_pkg::carry_t       in_carry,
    output logic                   out_valid,
    output logic [((NUM_W + lsdb_pkg::DIV_STEPS - 1) / lsdb_pkg::DIV_STEPS)
                  * lsdb_pkg::DIV_STEPS - 1:0] out_quot,
    output lsdb_pkg::carry_t       out_carry
);

    localparam int unsigned STEPS = lsdb_pkg::DIV_STEPS;
    localparam int unsigned NS    = (NUM_W + STEPS - 1) / STEPS;
    localparam int unsigned PAD_W = NS * STEPS;

    logic                   valid_reg [NS];
    logic [PAD_W-1:0]       num_reg   [NS];
    logic [DEN_W-1:0]       rem_reg   [NS];
    logic [DEN_W-1:0]       den_reg   [NS];
    lsdb_pkg::carry_t       carry_reg [NS];

    logic [PAD_W-1:0]       num_next  [NS];
    logic [DEN_W-1:0]       rem_next  [NS];

    for (genvar i = 0; i < NS; i++)
    begin : g_stage
        logic                   v_in;
        logic [PAD_W-1:0]       n_in;
        logic [DEN_W-1:0]       r_in;
        logic [DEN_W-1:0]       d_in;
        lsdb_pkg::carry_t       c_in;

        if (i == 0)
        begin : g_first
            assign v_in = in_valid;
            assign n_in = PAD_W'(in_num);
            assign r_in = '0;
            assign d_in = in_den;
            assign c_in = in_carry;
        end
        else
        begin : g_next
            assign v_in = valid_reg[i-1];
            assign n_in = num_reg[i-1];
            assign r_in = rem_reg[i-1];
            assign d_in = den_reg[i-1];
            assign c_in = carry_reg[i-1];
        end

        // restoring division, a few quotient bits per stage
        always_comb
        begin
            logic [DEN_W:0]   t;
            logic [PAD_W-1:0] n;
            logic [DEN_W-1:0] r;
            logic             q;
            n = n_in;
            r = r_in;
            for (int s = 0; s < STEPS; s++)
            begin
                t = {r, n[PAD_W-1]};
                if (t >= {1'b0, d_in})
                begin
                    t = t - {1'b0, d_in};
                    q = 1'b1;
                end
                else
                begin
                    q = 1'b0;
                end
                r = t[DEN_W-1:0];
                n = {n[PAD_W-2:0], q};
            end
            num_next[i] = n;
            rem_next[i] = r;
        end

        // valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (en)
                valid_reg[i] <= v_in;
        end

        // payload
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[i]   <= num_next[i];
                rem_reg[i]   <= rem_next[i];
                den_reg[i]   <= d_in;
                carry_reg[i] <= c_in;
            end
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign out_quot  = num_reg[NS-1];
    assign out_carry = carry_reg[NS-1];

endmodule

`default_nettype wire

@@ rtl/lsdb_mstage.sv @@
`default_nettype none

module lsdb_mstage #(
    parameter int unsigned FRAC_W = 32,
    parameter int unsigned K      = 1
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 en,
    input  wire                 in_valid,
    input  lsdb_pkg::carry_t    in_carry,
    input  wire  [FRAC_W-1:0]   in_frac,
    output logic                out_valid,
    output lsdb_pkg::carry_t    out_carry,
    output logic [FRAC_W-1:0]   out_frac
);

    localparam logic [63:0] ROOT = lsdb_pkg::exp_root(K);

    // first half: partial products
    logic                   valid_a_reg;
    lsdb_pkg::carry_t       carry_a_reg;
    logic [FRAC_W-1:0]      frac_a_reg;
    logic [63:0]            pp_ll_reg;
    logic [63:0]            pp_lh_reg;
    logic [63:0]            pp_hl_reg;
    logic [63:0]            pp_hh_reg;

    // second half: sum and select
    logic                   valid_reg;
    lsdb_pkg::carry_t       carry_reg;
    logic [FRAC_W-1:0]      frac_reg;

    logic [63:0]            mult_a;
    logic [63:0]            mult_b;
    logic [127:0]           prod;
    logic [63:0]            mant_next;
    logic [FRAC_W-1:0]      frac_next;

    // shared multiplier: squaring for the log, root product for the exp
    assign mult_a = in_carry.word;
    assign mult_b = (in_carry.info.op == lsdb_pkg::OP_INDEX) ? in_carry.word : ROOT;

    // valid bit, first half
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_a_reg <= 1'b0;
        else if (en)
            valid_a_reg <= in_valid;
    end

    // four 32 by 32 partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_ll_reg   <= 64'(mult_a[31:0])  * 64'(mult_b[31:0]);
            pp_lh_reg   <= 64'(mult_a[31:0])  * 64'(mult_b[63:32]);
            pp_hl_reg   <= 64'(mult_a[63:32]) * 64'(mult_b[31:0]);
            pp_hh_reg   <= 64'(mult_a[63:32]) * 64'(mult_b[63:32]);
            carry_a_reg <= in_carry;
            frac_a_reg  <= in_frac;
        end
    end

    // add up the partial products
    assign prod = {pp_hh_reg, pp_ll_reg}
                + {32'd0, pp_lh_reg, 32'd0}
                + {32'd0, pp_hl_reg, 32'd0};

    always_comb
    begin
        if (carry_a_reg.info.op == lsdb_pkg::OP_INDEX)
        begin
            mant_next = prod[127] ? prod[127:64] : prod[126:63];
            frac_next = {frac_a_reg[FRAC_W-2:0], prod[127]};
        end
        else
        begin
            mant_next = frac_a_reg[FRAC_W-K] ? prod[126:63] : carry_a_reg.word;
            frac_next = frac_a_reg;
        end
    end

    // valid bit, second half
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_a_reg;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            carry_reg.info <= carry_a_reg.info;
            carry_reg.word <= mant_next;
            frac_reg       <= frac_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_carry = carry_reg;
    assign out_frac  = frac_reg;

endmodule

`default_nettype wire

@@ rtl/log_scale_distance_bucket.sv @@
// throughput: one word per cycle unless the output word stalls; a multiplier stage per fraction bit sets the depth
// the whole pipeline holds only while the output word waits to be taken
// reset: asynchronous, active low; clears valid bits, bit_span and bucket_count to 64
`default_nettype none

module log_scale_distance_bucket #(
    parameter int unsigned LOG_FRAC_BITS = 32
) (
    input  wire          clk,
    input  wire          rst_n,
    lsdb_if.sink         req,
    lsdb_if.source       rsp,
    input  wire          cfg_we,
    input  wire  [0:0]   cfg_index,
    input  wire  [lsdb_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned F      = LOG_FRAC_BITS;
    localparam int unsigned STEPS  = lsdb_pkg::DIV_STEPS;
    localparam int unsigned NUMA_W = lsdb_pkg::PROD_W + F;
    localparam int unsigned PADA_W = ((NUMA_W + STEPS - 1) / STEPS) * STEPS;
    localparam int unsigned NUMB_W = lsdb_pkg::SCALED_W;
    localparam int unsigned PADB_W = ((NUMB_W + STEPS - 1) / STEPS) * STEPS;

    // configuration registers
    logic [6:0]  span_reg;
    logic [10:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_reg <= 7'd64;
            cnt_reg  <= 11'd64;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lsdb_pkg::REG_BIT_SPAN:     span_reg <= cfg_data[6:0];
                lsdb_pkg::REG_BUCKET_COUNT: cnt_reg  <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // global advance: stall only while the output word waits
    logic out_valid_reg;
    logic adv;

    assign adv       = !out_valid_reg || rsp.ready;
    assign req.ready = adv;

    // front stage: clamp, msb search, normalise, bucket product
    logic [6:0]            span_u;
    logic [10:0]           cnt_u;
    logic [5:0]            msb;
    lsdb_pkg::carry_t      s0_carry_next;
    logic [lsdb_pkg::PROD_W-1:0] s0_prod_next;

    logic                  s0_valid_reg;
    lsdb_pkg::carry_t      s0_carry_reg;
    logic [lsdb_pkg::PROD_W-1:0] s0_prod_reg;

    always_comb
    begin
        if (span_reg == 7'd0)
            span_u = 7'd1;
        else if (span_reg > lsdb_pkg::MAX_BIT_SPAN)
            span_u = lsdb_pkg::MAX_BIT_SPAN;
        else
            span_u = span_reg;

        if (cnt_reg == 11'd0)
            cnt_u = 11'd1;
        else if (cnt_reg > lsdb_pkg::MAX_BUCKETS)
            cnt_u = lsdb_pkg::MAX_BUCKETS;
        else
            cnt_u = cnt_reg;

        msb = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (req.data.distance[i])
                msb = 6'(i);
        end

        s0_carry_next.info.op        = lsdb_pkg::op_t'(req.data.operation);
        s0_carry_next.info.zero_dist = (req.data.distance == 64'd0);
        s0_carry_next.info.sat       = 1'b0;
        s0_carry_next.info.oob       = (req.data.bucket >= cnt_u);
        s0_carry_next.info.expo      = {1'b0, msb};
        s0_carry_next.info.span      = span_u;
        s0_carry_next.info.cnt       = cnt_u;
        s0_carry_next.word           = req.data.distance << (6'd63 - msb);
        s0_prod_next = lsdb_pkg::PROD_W'(req.data.bucket) * lsdb_pkg::PROD_W'(span_u);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (adv)
            s0_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_carry_reg <= s0_carry_next;
            s0_prod_reg  <= s0_prod_next;
        end
    end

    // exponent division: bucket * span * 2^F / count
    logic                  diva_valid;
    logic [PADA_W-1:0]     diva_quot;
    lsdb_pkg::carry_t      diva_carry;

    lsdb_div #(
        .NUM_W (NUMA_W),
        .DEN_W (11)
    ) u_diva (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s0_valid_reg),
        .in_num    ({s0_prod_reg, {F{1'b0}}}),
        .in_den    (s0_carry_reg.info.cnt),
        .in_carry  (s0_carry_reg),
        .out_valid (diva_valid),
        .out_quot  (diva_quot),
        .out_carry (diva_carry)
    );

    // split the exponent into integer and fraction parts
    logic [5:0]            exp_q;
    logic [F-1:0]          exp_fr;
    logic                  chain_valid [F+1];
    lsdb_pkg::carry_t      chain_carry [F+1];
    logic [F-1:0]          chain_frac  [F+1];

    assign exp_q  = diva_quot[F+5:F];
    assign exp_fr = diva_quot[F-1:0];

    always_comb
    begin
        chain_valid[0] = diva_valid;
        chain_carry[0] = diva_carry;
        chain_frac[0]  = '0;
        if (diva_carry.info.op == lsdb_pkg::OP_BOUNDARY)
        begin
            chain_carry[0].word = {1'b1, 63'd0};
            chain_frac[0]       = {F{1'b0}} - exp_fr;
            if (exp_fr == '0)
                chain_carry[0].info.expo = 7'd64 - {1'b0, exp_q};
            else
                chain_carry[0].info.expo = 7'd63 - {1'b0, exp_q};
            chain_carry[0].info.sat = (exp_fr == '0) && (exp_q == 6'd0);
        end
    end

    // one multiplier stage per fraction bit
    for (genvar k = 1; k <= F; k++)
    begin : g_mul
        lsdb_mstage #(
            .FRAC_W (F),
            .K      (k)
        ) u_mstage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (chain_valid[k-1]),
            .in_carry  (chain_carry[k-1]),
            .in_frac   (chain_frac[k-1]),
            .out_valid (chain_valid[k]),
            .out_carry (chain_carry[k]),
            .out_frac  (chain_frac[k])
        );
    end

    // finishing stage: scale the log term, or shift and round the boundary
    lsdb_pkg::carry_t      mc;
    logic [F+6:0]          log_term;
    logic [F+17:0]         scaled;
    logic [127:0]          shifted;
    logic [127:0]          rounded;
    lsdb_pkg::carry_t      fin_carry_next;
    logic                  fin_valid_reg;
    lsdb_pkg::carry_t      fin_carry_reg;

    assign mc = chain_carry[F];

    always_comb
    begin
        log_term = {7'd64, {F{1'b0}}} - {1'b0, mc.info.expo[5:0], chain_frac[F]};
        scaled   = (F+18)'(log_term) * (F+18)'(mc.info.cnt);
        shifted  = 128'(mc.word) << mc.info.expo[5:0];
        rounded  = shifted + {65'd0, 1'b1, 62'd0};
        fin_carry_next = mc;
        if (mc.info.op == lsdb_pkg::OP_INDEX)
            fin_carry_next.word = 64'(scaled[F+NUMB_W-1:F]);
        else if (mc.info.oob)
            fin_carry_next.word = 64'd0;
        else if (mc.info.sat || rounded[127])
            fin_carry_next.word = '1;
        else
            fin_carry_next.word = rounded[126:63];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_valid_reg <= 1'b0;
        else if (adv)
            fin_valid_reg <= chain_valid[F];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            fin_carry_reg <= fin_carry_next;
    end

    // index division by the bit span
    logic                  divb_valid;
    logic [PADB_W-1:0]     divb_quot;
    lsdb_pkg::carry_t      divb_carry;

    lsdb_div #(
        .NUM_W (NUMB_W),
        .DEN_W (7)
    ) u_divb (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (fin_valid_reg),
        .in_num    (fin_carry_reg.word[NUMB_W-1:0]),
        .in_den    (fin_carry_reg.info.span),
        .in_carry  (fin_carry_reg),
        .out_valid (divb_valid),
        .out_quot  (divb_quot),
        .out_carry (divb_carry)
    );

    // output register: clamp the index and pick the field
    logic [10:0]           last_bucket;
    logic [NUMB_W-1:0]     idx_raw;
    logic [10:0]           idx_sel;
    lsdb_pkg::out_word_t   out_data_next;
    lsdb_pkg::out_word_t   out_data_reg;

    always_comb
    begin
        last_bucket = divb_carry.info.cnt - 11'd1;
        idx_raw     = divb_quot[NUMB_W-1:0];
        if (divb_carry.info.zero_dist || idx_raw >= NUMB_W'(last_bucket))
            idx_sel = last_bucket;
        else
            idx_sel = idx_raw[10:0];
        if (divb_carry.info.op == lsdb_pkg::OP_INDEX)
        begin
            out_data_next.bucket_index = idx_sel[9:0];
            out_data_next.boundary     = 64'd0;
        end
        else
        begin
            out_data_next.bucket_index = 10'd0;
            out_data_next.boundary     = divb_carry.word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= divb_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_data_reg <= out_data_next;
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

endmodule

`default_nettype wire

@@ rtl/lsdb_chk.sv @@
`default_nettype none

module lsdb_chk (
    input wire                   clk,
    input wire                   rst_n,
    input wire                   req_valid,
    input wire                   req_ready,
    input wire                   rsp_valid,
    input wire                   rsp_ready,
    input lsdb_pkg::out_word_t   rsp_data
);

    // a waiting output word holds still
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("output word changed while stalled");

    // input is refused only while the output word is stuck
    a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> rsp_valid && !rsp_ready)
        else $error("input refused without output back-pressure");

    // each word carries one result only
    a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.bucket_index != 10'd0 |-> rsp_data.boundary == 64'd0)
        else $error("both result fields set");

    // nothing leaves straight out of reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !rsp_valid)
        else $error("output valid out of reset");

    // taking the output word frees the input
    a_ready_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready |-> req_ready)
        else $error("input refused while output taken");

endmodule

bind log_scale_distance_bucket lsdb_chk u_lsdb_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

`default_nettype wire
